[sv/chs_pkg.sv]
// Package for the chained hash set core: types, constants and hash helpers.
// No dependencies; used by chs_seq, the top level and the checker.
`timescale 1ns / 1ps
package chs_pkg;
   localparam int BucketsDefault = 64;
   localparam int SlotsDefault   = 8;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 7;
   localparam logic [CsrIdxW-1:0] CSR_BUCKET_COUNT = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_MODE     = 1'b1;
   localparam logic [1:0] MODE_16 = 2'd0;
   localparam logic [1:0] MODE_32 = 2'd1;
   localparam logic       KIND_ADD = 1'b0;
   localparam logic [63:0] MIX64_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX64_B = 64'h94d049bb133111eb;
   localparam logic [31:0] MIX32_K = 32'h045d9f3b;

   typedef struct packed {
      logic        kind;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic hit;
      logic bucket_full;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_MUL, ST_MULW, ST_MOD, ST_FILL, ST_FRD, ST_RD, ST_CMP, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_64A, OP_64B, OP_64B2, OP_32A, OP_32B
   } mop_type;
endpackage

[sv/chs_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module chs_ram #(
   parameter int Width = 64,
   parameter int Depth = 512
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
   input  logic [Width-1:0]                            wdata,
   output logic [Width-1:0]                            rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

[sv/chs_mul.sv]
// Shared 64-bit multiplier built from three 32x32 partial products over cycles.
// No dependencies.
`timescale 1ns / 1ps
module chs_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] prod
);
   logic [2:0]  step_ff, step_in;
   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [31:0] ma, mb;
   logic [63:0] pp_ff;

   always_comb begin
      unique case (step_ff)
         3'd1: begin ma = a_ff[31:0];  mb = b_ff[31:0];  end
         3'd2: begin ma = a_ff[63:32]; mb = b_ff[31:0];  end
         3'd3: begin ma = a_ff[31:0];  mb = b_ff[63:32]; end
         default: begin ma = 32'd0; mb = 32'd0; end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      acc_in  = acc_ff;
      if (start) begin
         step_in = 3'd1;
         acc_in  = 64'd0;
      end else if (step_ff != 3'd0) begin
         step_in = (step_ff == 3'd4) ? 3'd0 : step_ff + 3'd1;
         unique case (step_ff)
            3'd2: acc_in = pp_ff;
            3'd3: acc_in = acc_ff + {pp_ff[31:0], 32'd0};
            3'd4: acc_in = acc_ff + {pp_ff[31:0], 32'd0};
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
      end else begin
         step_ff <= step_in;
      end
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      pp_ff  <= 64'(ma * mb);
      acc_ff <= acc_in;
   end

   // Partial products for steps 1..3 land in pp_ff in the following cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         done <= 1'b0;
      end else begin
         done <= (step_ff == 3'd4);
      end
   end
   assign prod = acc_ff;
endmodule

[sv/chs_seq.sv]
// Sequencer: hash mixing, bucket modulo by repeated subtraction, slot search.
// Depends on chs_pkg, chs_mul and chs_ram.
`timescale 1ns / 1ps
module chs_seq #(
   parameter int Buckets = chs_pkg::BucketsDefault,
   parameter int Slots   = chs_pkg::SlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        bucket_count,
   input  logic [1:0]        key_mode,
   input  logic              req_valid,
   output logic              req_stall,
   input  chs_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output chs_pkg::rsp_type  rsp_word
);
   localparam int BW = (Buckets > 1) ? $clog2(Buckets) : 1;
   localparam int FW = $clog2(Slots + 1);
   localparam int AW = $clog2(Buckets * Slots + 1);
   localparam int RW = (Buckets * Slots > 1) ? $clog2(Buckets * Slots) : 1;
   localparam int CW = $clog2(Buckets + 1);

   chs_pkg::state_type st_ff, st_in;
   chs_pkg::mop_type   op_ff, op_in;
   logic        kind_ff, kind_in;
   logic [63:0] key_ff, key_in, x_ff, x_in;
   logic [63:0] div_ff, div_in;
   logic [6:0]  sh_ff, sh_in;
   logic [CW-1:0] nb_ff, nb_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [FW-1:0] fill_ff, fill_in, idx_ff, idx_in;
   logic        found_ff, found_in;
   logic        vld_ff, vld_in;
   chs_pkg::rsp_type rsp_ff, rsp_in;
   logic        mstart;
   logic [63:0] ma, mb, mprod;
   logic        mdone;
   logic        fill_we;
   logic [BW-1:0] fill_addr;
   logic [FW-1:0] fill_wdata, fill_rd;
   logic        rwe;
   logic [AW-1:0] raddr;
   logic [63:0] rdata;
   logic [CW-1:0] nb_sat;
   logic [63:0] pm, rem;

   chs_mul u_mul (.clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .prod(mprod));

   chs_ram #(.Width(64), .Depth(Buckets * Slots)) u_ram (.clock(clock),
      .we(rwe), .addr(raddr[RW-1:0]), .wdata(key_ff),
      .rdata(rdata));

   chs_ram #(.Width(FW), .Depth(Buckets)) u_fill (.clock(clock),
      .we(fill_we), .addr(fill_addr), .wdata(fill_wdata),
      .rdata(fill_rd));

   always_comb begin
      if (bucket_count == 7'd0) begin
         nb_sat = CW'(1);
      end else if ({25'd0, bucket_count} > Buckets) begin
         nb_sat = CW'(Buckets);
      end else begin
         nb_sat = CW'(bucket_count);
      end
   end

   assign pm  = {{(64-CW){1'b0}}, nb_ff} << sh_ff;
   assign rem = (div_ff >= pm) ? div_ff - pm : div_ff;
   assign raddr = AW'(bkt_ff) * AW'(Slots) + AW'(idx_ff);

   always_comb begin
      st_in = st_ff; op_in = op_ff; kind_in = kind_ff; key_in = key_ff; x_in = x_ff;
      div_in = div_ff; sh_in = sh_ff; nb_in = nb_ff; bkt_in = bkt_ff;
      fill_in = fill_ff; idx_in = idx_ff; found_in = found_ff;
      vld_in = vld_ff; rsp_in = rsp_ff; clr_in = clr_ff;
      mstart = 1'b0; ma = 64'd0; mb = 64'd0; rwe = 1'b0;
      fill_we = 1'b0; fill_addr = bkt_ff; fill_wdata = fill_ff + FW'(1);
      if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end
      unique case (st_ff)
         chs_pkg::ST_CLR: begin
            fill_we = 1'b1;
            fill_addr = clr_ff;
            fill_wdata = '0;
            if (clr_ff == BW'(Buckets - 1)) begin
               st_in = chs_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + BW'(1);
            end
         end
         chs_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_word.kind;
               nb_in = nb_sat;
               priority if (key_mode == chs_pkg::MODE_16) begin
                  key_in = {48'd0, req_word.key[15:0]};
                  op_in = chs_pkg::OP_32A;
               end else if (key_mode == chs_pkg::MODE_32) begin
                  key_in = {32'd0, req_word.key[31:0]};
                  op_in = chs_pkg::OP_32A;
               end else begin
                  key_in = req_word.key;
                  op_in = chs_pkg::OP_64A;
               end
               st_in = chs_pkg::ST_MUL;
            end
         end
         chs_pkg::ST_MUL: begin
            mstart = 1'b1;
            unique case (op_ff)
               chs_pkg::OP_64A: begin ma = key_ff ^ (key_ff >> 30); mb = chs_pkg::MIX64_A; end
               chs_pkg::OP_64B: begin ma = x_ff ^ (x_ff >> 27); mb = chs_pkg::MIX64_B; end
               chs_pkg::OP_32A: begin
                  ma = {32'd0, key_ff[31:0] ^ (key_ff[31:0] >> 16)};
                  mb = {32'd0, chs_pkg::MIX32_K};
               end
               default: begin
                  ma = {32'd0, x_ff[31:0] ^ (x_ff[31:0] >> 16)};
                  mb = {32'd0, chs_pkg::MIX32_K};
               end
            endcase
            st_in = chs_pkg::ST_MULW;
         end
         chs_pkg::ST_MULW: begin
            if (mdone) begin
               st_in = chs_pkg::ST_MUL;
               unique case (op_ff)
                  chs_pkg::OP_64A: begin x_in = mprod; op_in = chs_pkg::OP_64B; end
                  chs_pkg::OP_32A: begin
                     x_in = {32'd0, mprod[31:0]}; op_in = chs_pkg::OP_32B;
                  end
                  chs_pkg::OP_64B: begin
                     div_in = mprod ^ (mprod >> 31); st_in = chs_pkg::ST_MOD;
                     sh_in = 7'd63;
                  end
                  default: begin
                     div_in = {32'd0, mprod[31:0] ^ (mprod[31:0] >> 16)};
                     if (key_mode == chs_pkg::MODE_16) begin
                        div_in[63:16] = 48'd0;
                     end
                     st_in = chs_pkg::ST_MOD;
                     sh_in = 7'd63;
                  end
               endcase
            end
         end
         chs_pkg::ST_MOD: begin
            // Restoring reduction one bit position a cycle, skipping shifts
            // that would push the divisor out of the word.
            if ((pm >> sh_ff) == {{(64-CW){1'b0}}, nb_ff}) begin
               div_in = rem;
            end
            if (sh_ff == 7'd0) begin
               st_in = chs_pkg::ST_FILL;
            end else begin
               sh_in = sh_ff - 7'd1;
            end
         end
         chs_pkg::ST_FILL: begin
            bkt_in = BW'(div_ff);
            st_in = chs_pkg::ST_FRD;
            idx_in = '0;
            found_in = 1'b0;
         end
         chs_pkg::ST_FRD: begin
            st_in = chs_pkg::ST_RD;
         end
         chs_pkg::ST_RD: begin
            fill_in = fill_rd;
            if (idx_ff >= fill_rd) begin
               st_in = chs_pkg::ST_DONE;
            end else begin
               st_in = chs_pkg::ST_CMP;
            end
         end
         chs_pkg::ST_CMP: begin
            if (rdata == key_ff) begin
               found_in = 1'b1;
               st_in = chs_pkg::ST_DONE;
            end else begin
               idx_in = idx_ff + FW'(1);
               st_in = chs_pkg::ST_RD;
            end
         end
         default: begin
            if (!vld_ff || !rsp_stall) begin
               rsp_in.hit = 1'b0;
               rsp_in.bucket_full = 1'b0;
               if (kind_ff != chs_pkg::KIND_ADD) begin
                  rsp_in.hit = found_ff;
               end else if (!found_ff) begin
                  if (fill_ff >= FW'(Slots)) begin
                     rsp_in.bucket_full = 1'b1;
                  end else begin
                     rsp_in.hit = 1'b1;
                     rwe = 1'b1;
                     fill_we = 1'b1;
                  end
               end
               vld_in = 1'b1;
               st_in = chs_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= chs_pkg::ST_CLR;
         vld_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
         clr_ff <= clr_in;
      end
      op_ff <= op_in; kind_ff <= kind_in; key_ff <= key_in; x_ff <= x_in;
      div_ff <= div_in; sh_ff <= sh_in; nb_ff <= nb_in; bkt_ff <= bkt_in;
      fill_ff <= fill_in; idx_ff <= idx_in; found_ff <= found_in; rsp_ff <= rsp_in;
   end

   assign req_stall = (st_ff != chs_pkg::ST_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_word  = rsp_ff;
endmodule

[sv/chained_hash_set_membership_core.sv]
// Chained hash set core: each accepted word goes through two passes of the shared
// multiplier, a 64-step bucket modulo, and a compare of the filled slots of its
// bucket in the RAM up to the first match. One word at a time: req_stall stays high
// until the response for the last word has been registered.
// Reset is synchronous; a clearing pass then zeroes the fill count of every bucket.
// Depends on chs_pkg and chs_seq.
`timescale 1ns / 1ps
module chained_hash_set_membership_core #(
   parameter int Buckets = chs_pkg::BucketsDefault,
   parameter int Slots   = chs_pkg::SlotsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [chs_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [chs_pkg::CsrDataW-1:0] csr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  chs_pkg::req_type             req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output chs_pkg::rsp_type             rsp_word
);
   logic [6:0] bucket_count_ff;
   logic [1:0] key_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= 7'd64;
         key_mode_ff     <= 2'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            chs_pkg::CSR_BUCKET_COUNT: bucket_count_ff <= csr_data;
            default:                   key_mode_ff <= csr_data[1:0];
         endcase
      end
   end

   chs_seq #(.Buckets(Buckets), .Slots(Slots)) u_seq (
      .clock(clock), .reset(reset), .bucket_count(bucket_count_ff),
      .key_mode(key_mode_ff), .req_valid(req_valid), .req_stall(req_stall),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_word(rsp_word));
endmodule

[sv/chs_checker.sv]
// Port checker for the chained hash set core, bound to the top level.
// Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input chs_pkg::rsp_type rsp_word
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word)) else $error("rsp");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.hit && rsp_word.bucket_full)) else $error("excl");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("busy");
   a_norsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid)) else $error("early");
endmodule

bind chained_hash_set_membership_core chs_checker u_chk (.clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_word(rsp_word));
